FILE: sv/gbn_pkg.sv
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int SEQ_SPACE   = 8;
  localparam int SEND_WINDOW = 7;

  // link event codes
  localparam logic [2:0] CMD_PKT = 3'd0;
  localparam logic [2:0] CMD_PHY = 3'd1;
  localparam logic [2:0] CMD_RX  = 3'd2;
  localparam logic [2:0] CMD_DTO = 3'd3;
  localparam logic [2:0] CMD_ATO = 3'd4;

  // received frame kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  // classified operations handed from front to back
  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_PKT     = 4'd1;
  localparam logic [3:0] OP_PHY     = 4'd2;
  localparam logic [3:0] OP_RX_BAD  = 4'd3;
  localparam logic [3:0] OP_RX_NAK  = 4'd4;
  localparam logic [3:0] OP_RX_DATA = 4'd5;
  localparam logic [3:0] OP_RX_ACK  = 4'd6;
  localparam logic [3:0] OP_DTO     = 4'd7;
  localparam logic [3:0] OP_ATO     = 4'd8;

  // result actions
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_SEND_DATA = 3'd1;
  localparam logic [2:0] ACT_SEND_ACK  = 3'd2;
  localparam logic [2:0] ACT_SEND_NAK  = 3'd3;
  localparam logic [2:0] ACT_DELIVER   = 3'd4;

  // ack timer commands
  localparam logic [1:0] ATC_NONE  = 2'd0;
  localparam logic [1:0] ATC_START = 2'd1;
  localparam logic [1:0] ATC_STOP  = 2'd2;

  typedef struct packed {
    logic [2:0] command;
    logic       crc_ok;
    logic [1:0] rx_kind;
    logic [2:0] rx_seq;
    logic [2:0] rx_ack;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] tx_seq;
    logic [2:0] tx_ack;
    logic [2:0] buffer_slot;
    logic [7:0] stop_timer_mask;
    logic [1:0] ack_timer_cmd;
    logic       network_enable;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] rx_seq;
    logic [2:0] rx_ack;
  } gbn_op_t;

endpackage

FILE: sv/gbn_front.sv
`timescale 1ns / 1ps

module gbn_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  gbn_pkg::in_item_t  in_data,
  output logic               q_valid,
  input  logic               q_pop,
  output gbn_pkg::gbn_op_t   q_data
);

  gbn_pkg::gbn_op_t q_mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  gbn_pkg::gbn_op_t cls;
  logic             do_push;
  logic             do_pop;

  // classify the request by event and frame kind; state-dependent checks are in the back
  always_comb begin
    cls.rx_seq = in_data.rx_seq;
    cls.rx_ack = in_data.rx_ack;
    unique case (in_data.command)
      gbn_pkg::CMD_PKT: cls.op = gbn_pkg::OP_PKT;
      gbn_pkg::CMD_PHY: cls.op = gbn_pkg::OP_PHY;
      gbn_pkg::CMD_RX: begin
        if (!in_data.crc_ok) begin
          cls.op = (in_data.rx_kind == gbn_pkg::KIND_DATA) ? gbn_pkg::OP_RX_BAD
                                                            : gbn_pkg::OP_NOP;
        end else if (in_data.rx_kind == gbn_pkg::KIND_NAK) begin
          cls.op = gbn_pkg::OP_RX_NAK;
        end else if (in_data.rx_kind == gbn_pkg::KIND_DATA) begin
          cls.op = gbn_pkg::OP_RX_DATA;
        end else begin
          cls.op = gbn_pkg::OP_RX_ACK;
        end
      end
      gbn_pkg::CMD_DTO: cls.op = gbn_pkg::OP_DTO;
      gbn_pkg::CMD_ATO: cls.op = gbn_pkg::OP_ATO;
      default:          cls.op = gbn_pkg::OP_NOP;
    endcase
  end

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_data  = q_mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

FILE: sv/gbn_back.sv
`timescale 1ns / 1ps

module gbn_back #(
  parameter int SEQ_SPACE   = gbn_pkg::SEQ_SPACE,
  parameter int SEND_WINDOW = gbn_pkg::SEND_WINDOW
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  gbn_pkg::gbn_op_t   q_data,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output gbn_pkg::out_item_t out_data
);

  localparam int SW = $clog2(SEQ_SPACE);
  localparam int CW = $clog2(SEND_WINDOW + 1);
  localparam int LW = (SEND_WINDOW > 1) ? $clog2(SEND_WINDOW) : 1;
  localparam int MW = (SW > CW) ? SW : CW;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_BURST = 1'b1;

  function automatic logic [SW-1:0] red_seq(input logic [2:0] v);
    logic [2:0] t;
    t = v;
    for (int k = 0; k < 4; k++) begin
      if (int'(t) >= SEQ_SPACE) t = t - 3'(SEQ_SPACE);
    end
    return SW'(t);
  endfunction

  function automatic logic [SW-1:0] inc_seq(input logic [SW-1:0] x);
    return (x == SW'(SEQ_SPACE - 1)) ? '0 : x + SW'(1);
  endfunction

  function automatic logic [SW-1:0] dec_seq(input logic [SW-1:0] x);
    return (x == '0) ? SW'(SEQ_SPACE - 1) : x - SW'(1);
  endfunction

  function automatic logic [SW-1:0] sub_seq(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] t;
    t = {1'b0, a} - {1'b0, b};
    if (a < b) t = t + (SW+1)'(SEQ_SPACE);
    return t[SW-1:0];
  endfunction

  function automatic logic [LW-1:0] inc_slot(input logic [LW-1:0] x);
    return (x == LW'(SEND_WINDOW - 1)) ? '0 : x + LW'(1);
  endfunction

  // bit s set when sequence s lies in [base, base + span] modulo the sequence space
  function automatic logic [7:0] seg_mask(input logic [SW-1:0] base, input logic [SW-1:0] span);
    logic [7:0]    m;
    logic [SW-1:0] off;
    m = '0;
    for (int s = 0; s < 8; s++) begin
      off = sub_seq(SW'(s), base);
      if (s < SEQ_SPACE && off <= span) m[s] = 1'b1;
    end
    return m;
  endfunction

  logic [SW-1:0] base_r, base_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] slot_r, slot_nxt;
  logic [SW-1:0] exp_r, exp_nxt;
  logic          phys_r, phys_nxt;
  logic [SW-1:0] head_r, head_nxt;
  logic          st_r, st_nxt;
  logic [SW-1:0] bseq_r, bseq_nxt;
  logic [LW-1:0] bslot_r, bslot_nxt;
  logic [CW-1:0] brem_r, brem_nxt;
  logic          out_valid_r, out_valid_nxt;
  gbn_pkg::out_item_t out_r;
  gbn_pkg::out_item_t res;

  logic          free;
  logic          emit;
  logic [SW-1:0] seq_v, ack_v, tgt, ack_off, piggy;
  logic          hit;
  logic [7:0]    ack_mask;
  logic [SW-1:0] base_ack;
  logic [CW-1:0] cnt_ack;
  logic          is_nak;
  logic [CW-1:0] gb_cnt;
  logic [SW-1:0] gb_base;
  logic [7:0]    gb_mask;
  logic [CW:0]   gb_tmp;
  logic [LW-1:0] gb_slot;

  assign free  = !out_valid_r || pop;
  assign emit  = free && (st_r == ST_BURST || q_valid);
  assign q_pop = free && st_r == ST_IDLE && q_valid;
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  // ack handling: slide the window through tgt if tgt is outstanding
  always_comb begin
    is_nak   = (q_data.op == gbn_pkg::OP_RX_NAK);
    seq_v    = red_seq(q_data.rx_seq);
    ack_v    = red_seq(q_data.rx_ack);
    tgt      = is_nak ? dec_seq(ack_v) : ack_v;
    ack_off  = sub_seq(tgt, base_r);
    hit      = MW'(ack_off) < MW'(cnt_r);
    ack_mask = hit ? seg_mask(base_r, ack_off) : 8'd0;
    base_ack = hit ? inc_seq(tgt) : base_r;
    cnt_ack  = hit ? CW'(MW'(cnt_r) - MW'(ack_off) - MW'(1)) : cnt_r;
    piggy    = dec_seq(exp_r);
    gb_cnt   = is_nak ? cnt_ack : cnt_r;
    gb_base  = is_nak ? base_ack : base_r;
    gb_mask  = is_nak ? ack_mask : 8'd0;
    // resend restarts at the slot of the oldest outstanding frame
    gb_tmp   = (CW+1)'(slot_r) + (CW+1)'(SEND_WINDOW) - (CW+1)'(gb_cnt);
    if (gb_tmp >= (CW+1)'(SEND_WINDOW)) gb_tmp = gb_tmp - (CW+1)'(SEND_WINDOW);
    gb_slot  = LW'(gb_tmp);
  end

  always_comb begin
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    exp_nxt       = exp_r;
    phys_nxt      = phys_r;
    head_nxt      = head_r;
    st_nxt        = st_r;
    bseq_nxt      = bseq_r;
    bslot_nxt     = bslot_r;
    brem_nxt      = brem_r;
    out_valid_nxt = out_valid_r;
    res           = '0;
    res.action        = gbn_pkg::ACT_NONE;
    res.ack_timer_cmd = gbn_pkg::ATC_NONE;
    res.last          = 1'b1;

    if (pop) out_valid_nxt = 1'b0;

    if (emit) begin
      out_valid_nxt = 1'b1;
      if (st_r == ST_BURST) begin
        res.action        = gbn_pkg::ACT_SEND_DATA;
        res.tx_seq        = 3'(bseq_r);
        res.tx_ack        = 3'(piggy);
        res.buffer_slot   = 3'(bslot_r);
        res.ack_timer_cmd = gbn_pkg::ATC_STOP;
        res.last          = (brem_r == CW'(1));
        bseq_nxt  = inc_seq(bseq_r);
        bslot_nxt = inc_slot(bslot_r);
        brem_nxt  = brem_r - CW'(1);
        if (brem_r == CW'(1)) st_nxt = ST_IDLE;
      end else begin
        unique case (q_data.op)
          gbn_pkg::OP_PKT: begin
            if (int'(cnt_r) < SEND_WINDOW) begin
              res.action        = gbn_pkg::ACT_SEND_DATA;
              res.tx_seq        = 3'(head_r);
              res.tx_ack        = 3'(piggy);
              res.buffer_slot   = 3'(slot_r);
              res.ack_timer_cmd = gbn_pkg::ATC_STOP;
              phys_nxt = 1'b0;
              slot_nxt = inc_slot(slot_r);
              head_nxt = inc_seq(head_r);
              cnt_nxt  = cnt_r + CW'(1);
            end
          end
          gbn_pkg::OP_PHY: phys_nxt = 1'b1;
          gbn_pkg::OP_RX_BAD: begin
            if (seq_v == exp_r) begin
              res.action        = gbn_pkg::ACT_SEND_NAK;
              res.tx_ack        = 3'(seq_v);
              res.ack_timer_cmd = gbn_pkg::ATC_STOP;
              phys_nxt = 1'b0;
            end
          end
          gbn_pkg::OP_RX_NAK, gbn_pkg::OP_DTO: begin
            base_nxt = gb_base;
            cnt_nxt  = gb_cnt;
            res.stop_timer_mask = gb_mask;
            if (gb_cnt != '0) begin
              res.action        = gbn_pkg::ACT_SEND_DATA;
              res.tx_seq        = 3'(gb_base);
              res.tx_ack        = 3'(piggy);
              res.buffer_slot   = 3'(gb_slot);
              res.ack_timer_cmd = gbn_pkg::ATC_STOP;
              phys_nxt = 1'b0;
              if (gb_cnt != CW'(1)) begin
                res.last  = 1'b0;
                st_nxt    = ST_BURST;
                bseq_nxt  = inc_seq(gb_base);
                bslot_nxt = inc_slot(gb_slot);
                brem_nxt  = gb_cnt - CW'(1);
              end
            end
          end
          gbn_pkg::OP_RX_DATA: begin
            base_nxt = base_ack;
            cnt_nxt  = cnt_ack;
            res.stop_timer_mask = ack_mask;
            if (seq_v == exp_r) begin
              exp_nxt           = inc_seq(exp_r);
              res.action        = gbn_pkg::ACT_DELIVER;
              res.ack_timer_cmd = gbn_pkg::ATC_START;
            end
          end
          gbn_pkg::OP_RX_ACK: begin
            base_nxt = base_ack;
            cnt_nxt  = cnt_ack;
            res.stop_timer_mask = ack_mask;
          end
          gbn_pkg::OP_ATO: begin
            res.action        = gbn_pkg::ACT_SEND_ACK;
            res.tx_ack        = 3'(piggy);
            res.ack_timer_cmd = gbn_pkg::ATC_STOP;
            phys_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      res.network_enable = (int'(cnt_nxt) < SEND_WINDOW) && phys_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      cnt_r       <= '0;
      slot_r      <= '0;
      exp_r       <= '0;
      phys_r      <= 1'b0;
      head_r      <= '0;
      st_r        <= ST_IDLE;
      brem_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
      slot_r      <= slot_nxt;
      exp_r       <= exp_nxt;
      phys_r      <= phys_nxt;
      head_r      <= head_nxt;
      st_r        <= st_nxt;
      brem_r      <= brem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bseq_r  <= bseq_nxt;
    bslot_r <= bslot_nxt;
    if (emit) out_r <= res;
  end

endmodule

FILE: sv/go_back_n_link_controller_unit.sv
`timescale 1ns / 1ps
// A request is queued at the accepting edge; its first result is registered onto out_data
// from the queue once the result side is free and no go-back burst is in progress.
// Throughput: one result per cycle while results are popped; a go-back burst gives one
// result per outstanding frame (up to SEND_WINDOW), set by the single back-end sequencer.
// Reset (rst_n low, synchronous): queues empty, window, slots and expected sequence zero,
// physical layer marked busy.
module go_back_n_link_controller_unit #(
  parameter int SEQ_SPACE   = gbn_pkg::SEQ_SPACE,
  parameter int SEND_WINDOW = gbn_pkg::SEND_WINDOW
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  gbn_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output gbn_pkg::out_item_t out_data
);

  logic             q_valid;
  logic             q_pop;
  gbn_pkg::gbn_op_t q_data;

  gbn_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_data  (q_data)
  );

  gbn_back #(
    .SEQ_SPACE   (SEQ_SPACE),
    .SEND_WINDOW (SEND_WINDOW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

FILE: sv/gbn_checker.sv
`timescale 1ns / 1ps

module gbn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               push,
  input logic               full,
  input gbn_pkg::in_item_t  in_data,
  input logic               empty,
  input logic               pop,
  input gbn_pkg::out_item_t out_data
);

  logic is_send;

  assign is_send = (out_data.action == gbn_pkg::ACT_SEND_DATA) ||
                   (out_data.action == gbn_pkg::ACT_SEND_ACK) ||
                   (out_data.action == gbn_pkg::ACT_SEND_NAK);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_known_request: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full |-> !$isunknown(in_data))
    else $error("accepted request carries unknown bits");

  // a burst keeps results coming back to back
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_data.last && pop |=> !empty)
    else $error("gap inside a multi-result request");

  a_send_stops_ack_timer: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && is_send |-> out_data.ack_timer_cmd == gbn_pkg::ATC_STOP)
    else $error("sent frame did not stop the ack timer");

  a_send_blocks_network: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && is_send |-> !out_data.network_enable)
    else $error("network enabled after a frame send");

endmodule

bind go_back_n_link_controller_unit gbn_checker u_gbn_checker (.*);
